// ===== design/zoned_page_frame_allocator_top_assert.svh =====
// ----------------------------------------------------------------------------
// zoned_page_frame_allocator_top_assert.svh
// Assertion macros shared by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef ZONED_PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH
`define ZONED_PAGE_FRAME_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ZPFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zpfa assertion failed");

// next-cycle implication, disabled in reset
`define ZPFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zpfa assertion failed");

`endif

// ===== design/zpfa_pkg.sv =====
// ----------------------------------------------------------------------------
// zpfa_pkg
// Shared constants, codes and controller/datapath bundles of the allocator.
// ----------------------------------------------------------------------------
package zpfa_pkg;

  localparam int PAGES    = 4096;
  localparam int PG_W     = 12;          // page index width
  localparam int LINK_W   = 13;          // link / count width, bit 12 = no link
  localparam int REF_BITS = 16;

  localparam logic [LINK_W-1:0]   NO_LINK   = 13'h1000;
  localparam logic [LINK_W-1:0]   PAGES_L   = 13'h1000;
  localparam logic [REF_BITS-1:0] REF_MAX   = 16'hFFFF;
  localparam logic [REF_BITS-1:0] REF_ONE   = 16'd1;

  // operation codes
  localparam logic [2:0] OP_MAKE_FREE = 3'd0;
  localparam logic [2:0] OP_ALLOC     = 3'd1;
  localparam logic [2:0] OP_HOLD      = 3'd2;
  localparam logic [2:0] OP_RELEASE   = 3'd3;

  // result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMEM  = 2'd1;
  localparam logic [1:0] ST_BAD    = 2'd2;
  localparam logic [1:0] ST_REFERR = 2'd3;

  // zone selectors
  localparam logic [1:0] ZONE_LOW = 2'd0;
  localparam logic [1:0] ZONE_MID = 2'd1;
  localparam logic [1:0] ZONE_TOP = 2'd2;

  // config register indexes
  localparam logic CFG_LOW_TOP = 1'b0;
  localparam logic CFG_MID_TOP = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic       load;
    logic       clr;
    logic       set_st;
    logic [1:0] st;
    logic       push1;
    logic       push2;
    logic       ref_upd;
    logic       next_page;
    logic       head_take;
    logic       zone_dec;
    logic       zone_init;
    logic       scan_eval;
    logic       unlink;
    logic       emit;
  } zpfa_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic clr_last;
    logic is_mf;
    logic is_alloc;
    logic is_hold;
    logic is_rel;
    logic cnt_zero;
    logic cnt_one;
    logic oob;
    logic pg_free;
    logic ref_zero;
    logic ref_one;
    logic ref_max;
    logic head_valid;
    logic zone_zero;
    logic scan_end;
    logic run_hit;
    logic last;
    logic out_busy;
  } zpfa_stat_t;

endpackage

// ===== design/zpfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// zpfa_ctrl
// Sequencer: clearing pass, per-page range walk, list take, run scan.
// ----------------------------------------------------------------------------
module zpfa_ctrl import zpfa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  zpfa_stat_t stat,
  output zpfa_cmd_t  cmd
);

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_DISP  = 14'b00000000000100,
    S_RADDR = 14'b00000000001000,
    S_REVAL = 14'b00000000010000,
    S_PUSH2 = 14'b00000000100000,
    S_NEXT  = 14'b00000001000000,
    S_A1    = 14'b00000010000000,
    S_AZONE = 14'b00000100000000,
    S_AADDR = 14'b00001000000000,
    S_AEVAL = 14'b00010000000000,
    S_UADDR = 14'b00100000000000,
    S_UDO   = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  assign s_tready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        priority if (stat.is_mf) begin
          state_next = stat.cnt_zero ? S_DONE : S_RADDR;
        end else if (stat.is_alloc) begin
          if (stat.cnt_zero) begin
            cmd.set_st = 1'b1; cmd.st = ST_BAD; state_next = S_DONE;
          end else begin
            state_next = stat.cnt_one ? S_A1 : S_AZONE;
          end
        end else if (stat.is_hold) begin
          state_next = S_RADDR;
        end else if (stat.is_rel) begin
          if (stat.cnt_zero) begin
            cmd.set_st = 1'b1; cmd.st = ST_BAD; state_next = S_DONE;
          end else begin
            state_next = S_RADDR;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      // page address presented, meta read in flight
      S_RADDR: begin
        if (stat.oob) begin
          cmd.set_st = 1'b1; cmd.st = ST_BAD; state_next = S_DONE;
        end else begin
          state_next = S_REVAL;
        end
      end
      S_REVAL: begin
        priority if (stat.pg_free) begin
          cmd.set_st = 1'b1; cmd.st = ST_BAD; state_next = S_DONE;
        end else if (stat.is_mf) begin
          if (!stat.ref_zero) begin
            cmd.set_st = 1'b1; cmd.st = ST_REFERR; state_next = S_DONE;
          end else begin
            cmd.push1 = 1'b1; state_next = S_PUSH2;
          end
        end else if (stat.is_hold) begin
          if (stat.ref_zero || stat.ref_max) begin
            cmd.set_st = 1'b1; cmd.st = ST_REFERR;
          end else begin
            cmd.ref_upd = 1'b1;
          end
          state_next = S_DONE;
        end else begin
          if (stat.ref_zero) begin
            cmd.set_st = 1'b1; cmd.st = ST_REFERR; state_next = S_DONE;
          end else if (stat.ref_one) begin
            cmd.push1 = 1'b1; state_next = S_PUSH2;
          end else begin
            cmd.ref_upd = 1'b1; state_next = S_NEXT;
          end
        end
      end
      S_PUSH2: begin
        cmd.push2  = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        if (stat.last) begin
          state_next = S_DONE;
        end else begin
          cmd.next_page = 1'b1; state_next = S_RADDR;
        end
      end
      // single page: head of highest allowed nonempty list
      S_A1: begin
        if (stat.head_valid) begin
          cmd.head_take = 1'b1; state_next = S_UADDR;
        end else if (stat.zone_zero) begin
          cmd.set_st = 1'b1; cmd.st = ST_NOMEM; state_next = S_DONE;
        end else begin
          cmd.zone_dec = 1'b1;
        end
      end
      S_AZONE: begin
        cmd.zone_init = 1'b1;
        state_next    = S_AADDR;
      end
      S_AADDR: begin
        if (stat.scan_end) begin
          if (stat.zone_zero) begin
            cmd.set_st = 1'b1; cmd.st = ST_NOMEM; state_next = S_DONE;
          end else begin
            cmd.zone_dec = 1'b1; state_next = S_AZONE;
          end
        end else begin
          state_next = S_AEVAL;
        end
      end
      S_AEVAL: begin
        cmd.scan_eval = 1'b1;
        state_next    = stat.run_hit ? S_UADDR : S_AADDR;
      end
      S_UADDR: state_next = S_UDO;
      S_UDO: begin
        cmd.unlink = 1'b1;
        if (stat.last) begin
          state_next = S_DONE;
        end else begin
          cmd.next_page = 1'b1; state_next = S_UADDR;
        end
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.emit = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

// ===== design/zpfa_dp.sv =====
// ----------------------------------------------------------------------------
// zpfa_dp
// Page tables (meta, next, prev), list heads, counters and result register.
// ----------------------------------------------------------------------------
module zpfa_dp import zpfa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [12:0] cfg_data,
  input  zpfa_cmd_t   cmd,
  output zpfa_stat_t  stat
);

  // meta entry: bit 16 free mark, bits 15:0 reference count
  logic [REF_BITS:0] meta_mem [PAGES];
  logic [LINK_W-1:0] nxt_mem  [PAGES];
  logic [LINK_W-1:0] prv_mem  [PAGES];
  logic [REF_BITS:0] meta_q;
  logic [LINK_W-1:0] nxt_q, prv_q;

  logic [LINK_W-1:0] low_top, mid_top;
  logic [LINK_W-1:0] heads [3];
  logic [LINK_W-1:0] total;
  logic [PG_W-1:0]   clr_addr;

  logic [2:0]        op;
  logic [LINK_W-1:0] cnt;
  logic [LINK_W-1:0] idx, i, run, hi, hsave;
  logic [1:0]        zcur;
  logic [1:0]        st;
  logic [PG_W-1:0]   first;

  logic [PG_W-1:0]   out_page;
  logic [1:0]        out_st;
  logic [LINK_W-1:0] out_free;

  logic [REF_BITS-1:0] ref_cur;
  logic [LINK_W-1:0]   head_sel, cap_a, cap_b, span_lo, span_hi;
  logic [LINK_W-1:0]   run_n, run_start;
  logic [1:0]          zpush, zsel;
  logic [1:0]          in_zone;

  logic                meta_we, nxt_we, prv_we;
  logic [PG_W-1:0]     meta_wa, nxt_wa, prv_wa;
  logic [REF_BITS:0]   meta_wd;
  logic [LINK_W-1:0]   nxt_wd, prv_wd;

  assign ref_cur  = meta_q[REF_BITS-1:0];
  assign head_sel = heads[zcur];
  assign in_zone  = s_tdata[29:28];
  assign zsel     = (in_zone == 2'd3) ? ZONE_TOP : in_zone;

  // zone of a page being pushed
  assign zpush = (idx < low_top) ? ZONE_LOW : (idx < mid_top) ? ZONE_MID : ZONE_TOP;

  // zone spans with boundaries cut to the page count
  assign cap_a = (low_top > PAGES_L) ? PAGES_L : low_top;
  assign cap_b = (mid_top > PAGES_L) ? PAGES_L : mid_top;
  always_comb begin
    unique case (zcur)
      ZONE_LOW: begin span_lo = '0;    span_hi = cap_a;   end
      ZONE_MID: begin span_lo = cap_a; span_hi = cap_b;   end
      default:  begin
        span_lo = (cap_a > cap_b) ? cap_a : cap_b;
        span_hi = PAGES_L;
      end
    endcase
  end

  // run scan
  assign run_n     = meta_q[REF_BITS] ? run + 13'd1 : '0;
  assign run_start = idx + 13'd1 - cnt;

  // status to controller
  always_comb begin
    stat.clr_last   = (clr_addr == PG_W'(PAGES - 1));
    stat.is_mf      = (op == OP_MAKE_FREE);
    stat.is_alloc   = (op == OP_ALLOC);
    stat.is_hold    = (op == OP_HOLD);
    stat.is_rel     = (op == OP_RELEASE);
    stat.cnt_zero   = (cnt == '0);
    stat.cnt_one    = (cnt == 13'd1);
    stat.oob        = idx[LINK_W-1];
    stat.pg_free    = meta_q[REF_BITS];
    stat.ref_zero   = (ref_cur == '0);
    stat.ref_one    = (ref_cur == REF_ONE);
    stat.ref_max    = (ref_cur == REF_MAX);
    stat.head_valid = !head_sel[LINK_W-1];
    stat.zone_zero  = (zcur == ZONE_LOW);
    stat.scan_end   = (idx >= hi);
    stat.run_hit    = (run_n == cnt);
    stat.last       = ((i + 13'd1) == cnt);
    stat.out_busy   = m_tvalid && !m_tready;
  end

  // meta write port
  always_comb begin
    meta_we = 1'b0;
    meta_wa = idx[PG_W-1:0];
    meta_wd = '0;
    priority if (cmd.clr) begin
      meta_we = 1'b1; meta_wa = clr_addr;
    end else if (cmd.push1) begin
      meta_we = 1'b1; meta_wd = {1'b1, {REF_BITS{1'b0}}};
    end else if (cmd.ref_upd) begin
      meta_we = 1'b1;
      meta_wd = {1'b0, (op == OP_HOLD) ? ref_cur + REF_ONE : ref_cur - REF_ONE};
    end else if (cmd.unlink) begin
      meta_we = 1'b1; meta_wd = {1'b0, REF_ONE};
    end
  end

  // link write ports
  always_comb begin
    nxt_we = 1'b0; nxt_wa = idx[PG_W-1:0]; nxt_wd = head_sel;
    prv_we = 1'b0; prv_wa = idx[PG_W-1:0]; prv_wd = NO_LINK;
    if (cmd.push1) begin
      nxt_we = 1'b1; nxt_wd = heads[zpush];
      prv_we = 1'b1;
    end
    if (cmd.push2 && !hsave[LINK_W-1]) begin
      prv_we = 1'b1; prv_wa = hsave[PG_W-1:0]; prv_wd = idx;
    end
    if (cmd.unlink) begin
      nxt_we = !prv_q[LINK_W-1]; nxt_wa = prv_q[PG_W-1:0]; nxt_wd = nxt_q;
      prv_we = !nxt_q[LINK_W-1]; prv_wa = nxt_q[PG_W-1:0]; prv_wd = prv_q;
    end
  end

  // memories: one write, registered read at the current page
  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (nxt_we)  nxt_mem[nxt_wa]   <= nxt_wd;
    if (prv_we)  prv_mem[prv_wa]   <= prv_wd;
    meta_q <= meta_mem[idx[PG_W-1:0]];
    nxt_q  <= nxt_mem[idx[PG_W-1:0]];
    prv_q  <= prv_mem[idx[PG_W-1:0]];
  end

  // control state: config, heads, free total, clear pointer, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      low_top  <= 13'd256;
      mid_top  <= 13'd4096;
      heads[0] <= NO_LINK;
      heads[1] <= NO_LINK;
      heads[2] <= NO_LINK;
      total    <= '0;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_LOW_TOP) low_top <= cfg_data;
        if (cfg_addr == CFG_MID_TOP) mid_top <= cfg_data;
      end
      if (cmd.clr) clr_addr <= clr_addr + 12'd1;
      if (cmd.push1) begin
        heads[zpush] <= idx;
        total        <= total + 13'd1;
      end
      if (cmd.unlink) begin
        if (prv_q[LINK_W-1]) begin
          for (int z = 0; z < 3; z++)
            if (heads[z] == idx) heads[z] <= nxt_q;
        end
        if (total != '0) total <= total - 13'd1;
      end
      if (cmd.emit)          m_tvalid <= 1'b1;
      else if (m_tready)     m_tvalid <= 1'b0;
    end
  end

  // operation payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= s_tdata[2:0];
      idx   <= {1'b0, s_tdata[14:3]};
      cnt   <= s_tdata[27:15];
      zcur  <= zsel;
      i     <= '0;
      st    <= ST_OK;
      first <= '0;
    end
    if (cmd.set_st)    st    <= cmd.st;
    if (cmd.push1)     hsave <= heads[zpush];
    if (cmd.next_page) begin
      i   <= i + 13'd1;
      idx <= idx + 13'd1;
    end
    if (cmd.head_take) begin
      idx   <= head_sel;
      first <= head_sel[PG_W-1:0];
    end
    if (cmd.zone_dec)  zcur <= zcur - 2'd1;
    if (cmd.zone_init) begin
      idx <= span_lo;
      hi  <= span_hi;
      run <= '0;
    end
    if (cmd.scan_eval) begin
      run <= run_n;
      if (run_n == cnt) begin
        idx   <= run_start;
        first <= run_start[PG_W-1:0];
      end else begin
        idx <= idx + 13'd1;
      end
    end
    if (cmd.emit) begin
      out_page <= first;
      out_st   <= st;
      out_free <= total;
    end
  end

  assign m_tdata = {5'd0, out_free, out_st, out_page};

endmodule

// ===== design/zoned_page_frame_allocator_top.sv =====
// ----------------------------------------------------------------------------
// zoned_page_frame_allocator_top
// Zoned physical page allocator with per-zone free lists and refcounts.
// ----------------------------------------------------------------------------
// One request at a time; each request gives one result beat. After reset a
// clearing pass over all 4096 page table entries zeroes the page table before
// the first request is taken. Hold reads its page once; make free walks the
// range page by page and puts each page onto a list; release walks the range
// page by page, with an extra list push when a page's count drops to zero; a
// single-page allocate takes the head of the highest allowed nonempty list,
// skipping empty zones; a run allocate scans each zone from its base, then
// unlinks each page taken. A new request is accepted while the previous
// result beat still waits on m_tready.
module zoned_page_frame_allocator_top import zpfa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // operation[2:0], page_number[14:3], count[27:15],
                                 // zone[29:28], zero[31:30]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // page_number_res[11:0], status[13:12],
                                 // free_pages[26:14], zero[31:27]
  input  logic        cfg_we,
  input  logic        cfg_addr,  // 0 low_zone_top, 1 mid_zone_top
  input  logic [12:0] cfg_data
);

  zpfa_cmd_t  cmd;
  zpfa_stat_t stat;

  zpfa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  zpfa_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

// ===== design/zpfa_chk.sv =====
// ----------------------------------------------------------------------------
// zpfa_chk
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "zoned_page_frame_allocator_top_assert.svh"

module zpfa_chk import zpfa_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // one request in flight: no accept right after an accept
  `ZPFA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

  // failed requests report page zero
  `ZPFA_ASSERT_NOW(a_fail_page_zero, m_tvalid && (m_tdata[13:12] != ST_OK), m_tdata[11:0] == 12'd0)

  // free count never exceeds the page count
  `ZPFA_ASSERT_NOW(a_free_bound, m_tvalid, m_tdata[26:14] <= PAGES_L)

  // stalled result beat stays put
  `ZPFA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind zoned_page_frame_allocator_top zpfa_chk u_zpfa_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/zoned_page_frame_allocator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zoned_page_frame_allocator_top_tb
// Self-checking bench for the zoned page allocator. It streams request beats
// through a queue-fed driver. It mirrors the page table, free lists and
// refcounts to predict every reply beat, and checks each reply field by field.
// Zone boundaries change between phases, and both sides stall at random.
// ----------------------------------------------------------------------------
module zoned_page_frame_allocator_top_tb;
  import zpfa_pkg::*;

  localparam int LIMIT = 100000000;
  localparam int SETTLE = 40;

  typedef struct packed {
    logic [11:0] first_page;
    logic [1:0]  status;
    logic [12:0] free_pages;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [12:0] cfg_data = '0;

  zoned_page_frame_allocator_top DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirrored allocator state
  logic [REF_BITS-1:0] frame_refs [PAGES];
  logic                frame_free [PAGES];
  logic [LINK_W-1:0]   link_next  [PAGES];
  logic [LINK_W-1:0]   link_prev  [PAGES];
  logic [LINK_W-1:0]   zone_head  [3];
  int unsigned         free_count;
  logic [12:0]         cfg_low = 13'd256;
  logic [12:0]         cfg_mid = 13'd4096;

  logic [31:0] request_q [$];
  reply_t      reply_q [$];
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_send = 0;
  int          errors = 0;
  int          cycles = 0;

  function automatic int zone_of(int p);
    if (p < cfg_low) return 0;
    if (p < cfg_mid) return 1;
    return 2;
  endfunction

  function automatic void list_push(int p);
    int z;
    z = zone_of(p);
    link_next[p] = zone_head[z];
    link_prev[p] = NO_LINK;
    if (zone_head[z] < PAGES_L) link_prev[zone_head[z][PG_W-1:0]] = LINK_W'(p);
    zone_head[z] = LINK_W'(p);
    frame_free[p] = 1'b1;
    free_count++;
  endfunction

  function automatic void list_take(int p);
    logic [LINK_W-1:0] n, v;
    n = link_next[p];
    v = link_prev[p];
    if (v < PAGES_L) link_next[v[PG_W-1:0]] = n;
    else for (int z = 0; z < 3; z++) if (zone_head[z] == p) zone_head[z] = n;
    if (n < PAGES_L) link_prev[n[PG_W-1:0]] = v;
    frame_free[p] = 1'b0;
    if (free_count > 0) free_count--;
    frame_refs[p] = REF_ONE;
  endfunction

  // status of a make-free (release_mode 0) or release (1) over a range
  function automatic logic [1:0] range_op(int base, int cnt, bit release_mode);
    int p;
    if (release_mode && cnt == 0) return ST_BAD;
    for (int i = 0; i < cnt; i++) begin
      p = base + i;
      if (p >= PAGES) return ST_BAD;
      if (frame_free[p]) return ST_BAD;
      if (!release_mode) begin
        if (frame_refs[p] != 0) return ST_REFERR;
        list_push(p);
      end else begin
        if (frame_refs[p] == 0) return ST_REFERR;
        frame_refs[p]--;
        if (frame_refs[p] == 0) list_push(p);
      end
    end
    return ST_OK;
  endfunction

  function automatic logic [1:0] alloc_op(int cnt, int top, output int first);
    int a, b, lo, hi, run, s;
    first = 0;
    if (cnt == 0) return ST_BAD;
    if (cnt == 1) begin
      for (int z = top; z >= 0; z--)
        if (zone_head[z] < PAGES_L) begin
          first = int'(zone_head[z][PG_W-1:0]);
          list_take(first);
          return ST_OK;
        end
      return ST_NOMEM;
    end
    a = (cfg_low > PAGES) ? PAGES : int'(cfg_low);
    b = (cfg_mid > PAGES) ? PAGES : int'(cfg_mid);
    for (int z = top; z >= 0; z--) begin
      lo = (z == 0) ? 0 : (z == 1) ? a : ((a > b) ? a : b);
      hi = (z == 0) ? a : (z == 1) ? b : PAGES;
      run = 0;
      for (int p = lo; p < hi; p++) begin
        run = frame_free[p] ? run + 1 : 0;
        if (run == cnt) begin
          s = p + 1 - cnt;
          for (int i = 0; i < cnt; i++) list_take(s + i);
          first = s;
          return ST_OK;
        end
      end
    end
    return ST_NOMEM;
  endfunction

  function automatic reply_t predict_reply(logic [31:0] beat);
    reply_t r;
    logic [2:0] op;
    int page, cnt, zn, first;
    op = beat[2:0];
    page = int'(beat[14:3]);
    cnt = int'(beat[27:15]);
    zn = (beat[29:28] > ZONE_TOP) ? int'(ZONE_TOP) : int'(beat[29:28]);
    first = 0;
    r.status = ST_OK;
    case (op)
      OP_MAKE_FREE: r.status = range_op(page, cnt, 1'b0);
      OP_ALLOC:     r.status = alloc_op(cnt, zn, first);
      OP_HOLD: begin
        if (frame_free[page]) r.status = ST_BAD;
        else if (frame_refs[page] == 0 || frame_refs[page] == REF_MAX) r.status = ST_REFERR;
        else frame_refs[page]++;
      end
      OP_RELEASE:   r.status = range_op(page, cnt, 1'b1);
      default: ;
    endcase
    r.first_page = 12'(first);
    r.free_pages = (free_count > 8191) ? 13'h1FFF : 13'(free_count);
    return r;
  endfunction

  function automatic logic [31:0] pack_req(logic [2:0] op, logic [11:0] page,
                                           logic [12:0] cnt, logic [1:0] zn);
    return {2'b00, zn, cnt, page, op};
  endfunction

  // request driver: predicts each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) reply_q.push_back(predict_reply(s_tdata));
      if (!s_tvalid || s_tready) begin
        if (request_q.size() > 0 && !hold_send && $urandom_range(99) >= send_idle) begin
          s_tvalid <= 1'b1;
          s_tdata  <= request_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // reply monitor
  always @(posedge clk) begin
    reply_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          $error("unexpected reply beat %h", m_tdata);
          errors++;
        end else begin
          e = reply_q.pop_front();
          if (m_tdata[11:0] !== e.first_page) begin
            $error("page_number_res expected %0d got %0d", e.first_page, m_tdata[11:0]);
            errors++;
          end
          if (m_tdata[13:12] !== e.status) begin
            $error("status expected %0d got %0d", e.status, m_tdata[13:12]);
            errors++;
          end
          if (m_tdata[26:14] !== e.free_pages) begin
            $error("free_pages expected %0d got %0d", e.free_pages, m_tdata[26:14]);
            errors++;
          end
        end
      end
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("zoned_page_frame_allocator_top_tb failed");
      $finish;
    end
  end

  task automatic drain();
    while (request_q.size() > 0 || s_tvalid || reply_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [12:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    if (idx == CFG_LOW_TOP) cfg_low = val;
    else cfg_mid = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // random traffic, mostly dense in a small page window
  task automatic queue_random(int n);
    logic [2:0]  op;
    logic [11:0] page;
    logic [12:0] cnt;
    int sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      op = (sel < 30) ? OP_MAKE_FREE : (sel < 60) ? OP_ALLOC : (sel < 75) ? OP_HOLD :
           (sel < 95) ? OP_RELEASE : 3'($urandom_range(7, 4));
      page = ($urandom_range(9) == 0) ? 12'($urandom()) : 12'($urandom_range(127));
      sel = $urandom_range(99);
      if (sel < 2) cnt = 13'($urandom());
      else if (sel < 4) cnt = 13'd0;
      else if (op == OP_ALLOC && sel < 60) cnt = 13'd1;
      else cnt = 13'($urandom_range(6, 1));
      request_q.push_back(pack_req(op, page, cnt, 2'($urandom_range(3))));
    end
  endtask

  initial begin
    for (int p = 0; p < PAGES; p++) begin
      frame_refs[p] = '0;
      frame_free[p] = 1'b0;
      link_next[p]  = NO_LINK;
      link_prev[p]  = NO_LINK;
    end
    for (int z = 0; z < 3; z++) zone_head[z] = NO_LINK;
    free_count = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_cfg(CFG_LOW_TOP, 13'd40);
    write_cfg(CFG_MID_TOP, 13'd90);

    // directed: edges of each operation
    send_idle = 23; recv_idle = 69;
    request_q.push_back(pack_req(OP_MAKE_FREE, 12'd0, 13'd0, ZONE_LOW));
    request_q.push_back(pack_req(OP_MAKE_FREE, 12'd0, 13'd64, ZONE_LOW));
    request_q.push_back(pack_req(OP_MAKE_FREE, 12'd10, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_ALLOC, 12'd0, 13'd0, ZONE_TOP));
    request_q.push_back(pack_req(OP_ALLOC, 12'd0, 13'd1, ZONE_TOP));
    request_q.push_back(pack_req(OP_ALLOC, 12'd0, 13'd1, 2'd3));
    request_q.push_back(pack_req(OP_ALLOC, 12'd0, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_ALLOC, 12'd0, 13'd4, ZONE_MID));
    request_q.push_back(pack_req(OP_HOLD, 12'd63, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_HOLD, 12'd20, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_HOLD, 12'd4000, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_RELEASE, 12'd63, 13'd0, ZONE_LOW));
    request_q.push_back(pack_req(OP_RELEASE, 12'd63, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_RELEASE, 12'd20, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_RELEASE, 12'd3000, 13'd2, ZONE_LOW));
    request_q.push_back(pack_req(OP_MAKE_FREE, 12'd63, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_MAKE_FREE, 12'd20, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_MAKE_FREE, 12'd4095, 13'd2, ZONE_TOP));
    request_q.push_back(pack_req(OP_ALLOC, 12'hFFF, 13'd4096, ZONE_TOP));
    request_q.push_back(pack_req(3'd4, 12'hFFF, 13'h1FFF, 2'd3));
    request_q.push_back(pack_req(3'd7, 12'd0, 13'd0, ZONE_LOW));
    queue_random(500);
    drain();

    // phase two: lowest zone empty, upper boundary past the table
    write_cfg(CFG_LOW_TOP, 13'd0);
    write_cfg(CFG_MID_TOP, 13'h1FFF);
    send_idle = 69; recv_idle = 23;
    queue_random(500);
    drain();

    // phase three: crossed boundaries, with a full drain in the middle
    write_cfg(CFG_LOW_TOP, 13'd100);
    write_cfg(CFG_MID_TOP, 13'd30);
    send_idle = 0; recv_idle = 0;
    queue_random(250);
    hold_send = 1;
    while (s_tvalid || reply_q.size() > 0) @(posedge clk);
    hold_send = 0;
    queue_random(250);
    drain();

    // phase four: both boundaries at the table end, then 20 holds on one page
    write_cfg(CFG_LOW_TOP, 13'd4096);
    write_cfg(CFG_MID_TOP, 13'd4096);
    queue_random(400);
    request_q.push_back(pack_req(OP_RELEASE, 12'd4090, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_MAKE_FREE, 12'd4090, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_ALLOC, 12'd0, 13'd1, ZONE_TOP));
    for (int i = 0; i < 20; i++)
      request_q.push_back(pack_req(OP_HOLD, 12'd4090, 13'd1, ZONE_LOW));
    request_q.push_back(pack_req(OP_RELEASE, 12'd4090, 13'd2, ZONE_LOW));
    drain();

    if (errors == 0) begin
      $display("zoned_page_frame_allocator_top_tb passed");
    end else begin
      $display("zoned_page_frame_allocator_top_tb failed");
    end
    $finish;
  end

endmodule
